// ===== sv/sbt_pkg.sv =====
`timescale 1ns / 1ps

package sbt_pkg;

  // Default sizing
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;

  // Fixed field widths
  localparam int FIELD_BITS     = 12;
  localparam int EXT_BITS       = 16;
  localparam int DIST_BITS      = 12;
  localparam int FRAME_BITS     = 32;
  localparam int COUNT_BITS     = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_TDATA_BITS  = 4 * FIELD_BITS;
  localparam int OUT_TDATA_BITS = 4 * FIELD_BITS + 2 * FRAME_BITS;
  localparam int OUT_TUSER_BITS = 2;

  // Register indexes
  localparam logic REG_MAX_DISTANCE = 1'b0;
  localparam logic REG_MIN_FRAMES   = 1'b1;

  // Register reset values
  localparam logic [DIST_BITS-1:0]     MAX_DISTANCE_RST = 12'd10;
  localparam logic [CFG_DATA_BITS-1:0] MIN_FRAMES_RST   = 16'd40;

  // Commands carried on the input tuser
  localparam logic CMD_BOX = 1'b0;
  localparam logic CMD_EOF = 1'b1;

  // Entry count limits
  localparam logic [COUNT_BITS-1:0] COUNT_INIT = 16'd1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 16'hFFFF;

endpackage

// ===== sv/sbt_ram.sv =====
`timescale 1ns / 1ps

module sbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sbt_match.sv =====
`timescale 1ns / 1ps

module sbt_match #(
  parameter int COORD_BITS = 12
) (
  input  logic [4*COORD_BITS-1:0]     box_a,
  input  logic [4*COORD_BITS-1:0]     box_b,
  input  logic [sbt_pkg::DIST_BITS-1:0] gap_limit,
  output logic                        hit
);

  import sbt_pkg::*;

  localparam int XW = (COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS;

  logic [3:0] near;

  // Compare each of x, y, width and height against the distance
  always_comb begin
    logic [XW-1:0] a;
    logic [XW-1:0] b;
    logic [XW-1:0] diff;
    for (int k = 0; k < 4; k++) begin
      a = XW'(box_a[k*COORD_BITS +: COORD_BITS]);
      b = XW'(box_b[k*COORD_BITS +: COORD_BITS]);
      diff = (a > b) ? (a - b) : (b - a);
      near[k] = diff < XW'(gap_limit);
    end
  end

  assign hit = &near;

endmodule

// ===== sv/stationary_box_tracker_core.sv =====
`timescale 1ns / 1ps

// Stationary box tracker.
// Input stream: s_tdata carries box_x, box_y, box_width, box_height; s_tuser
// carries the command (box or end of frame). Output stream: one beat per
// stationary object removed at end of frame, or one empty marker beat when
// there is none; the final beat of a frame has m_tlast set.
// The tracked table lives in one single-port-write RAM with a registered
// read, scanned one entry per cycle while the sweep is not halted.
// A box is appended straight away when the table is empty, else the entries
// are scanned in order up to the first match (at most the fill).
// An end of frame sweeps every stored entry (read, compact, report), then
// releases the final beat; a frame's first report leaves once the second
// report is found, or with the final beat. s_tready is high only between items.
// Configuration writes must go in while idle; the block does not enforce it.
// Reset empties the table (fill count to zero), zeroes the frame counter and
// the overflow flag, and loads the register defaults; no clearing pass.
// When the receiver stalls, the result beat holds in the output register;
// the sweep keeps one report pending and halts on the next one until the
// output register frees.

module stationary_box_tracker_core #(
  parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = sbt_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sbt_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // box_x, box_y, box_width, box_height
  input  logic                                s_tuser,  // command
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // found_x, found_y, found_width, found_height, first_seen_frame, last_seen_frame
  output logic [sbt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  output logic [sbt_pkg::OUT_TUSER_BITS-1:0]  m_tuser,  // found, table_overflow
  output logic                                m_tlast,  // last_of_frame
  // Configuration
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sbt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import sbt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int BW = 4 * COORD_BITS;
  localparam int EW = BW + 2 * FRAME_BITS + COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [NW-1:0]         cur, cur_next, cur_inc;
  logic [NW-1:0]         fill, fill_next;
  logic [NW-1:0]         wptr, wptr_next;
  logic [BW-1:0]         box_reg, in_box;
  logic                  box_take;
  logic [FRAME_BITS-1:0] frame_cnt, frame_next;
  logic                  ovf_seen, ovf_next;
  logic [DIST_BITS-1:0]  max_dist;
  logic [COUNT_BITS-1:0] min_needed;

  logic                  have_pend, have_pend_next, pend_take;
  logic [BW-1:0]         pend_box;
  logic [FRAME_BITS-1:0] pend_first, pend_last;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, rd_data;
  logic [BW-1:0]         rd_box;
  logic [FRAME_BITS-1:0] rd_first, rd_last;
  logic [COUNT_BITS-1:0] rd_count, count_inc;

  logic                  hit, keep, report, last_one, out_ok, advance;
  logic                  out_load, out_found, out_tlast;
  logic [BW-1:0]         out_box;
  logic [FRAME_BITS-1:0] out_first, out_last_f;
  logic [4*FIELD_BITS-1:0] out_box12;

  // Entry store
  sbt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign rd_box   = rd_data[BW-1:0];
  assign rd_first = rd_data[BW +: FRAME_BITS];
  assign rd_last  = rd_data[BW+FRAME_BITS +: FRAME_BITS];
  assign rd_count = rd_data[BW+2*FRAME_BITS +: COUNT_BITS];

  // Distance test of the held box against the entry just read
  sbt_match #(
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .box_a     (box_reg),
    .box_b     (rd_box),
    .gap_limit (max_dist),
    .hit       (hit)
  );

  // Narrow the input fields to the stored coordinate width
  always_comb begin
    logic [EXT_BITS-1:0] ext;
    for (int k = 0; k < 4; k++) begin
      ext = EXT_BITS'(s_tdata[k*FIELD_BITS +: FIELD_BITS]);
      in_box[k*COORD_BITS +: COORD_BITS] = ext[COORD_BITS-1:0];
    end
  end

  // Widen or narrow the stored box to the result field width
  always_comb begin
    logic [EXT_BITS-1:0] ext;
    for (int k = 0; k < 4; k++) begin
      ext = EXT_BITS'(out_box[k*COORD_BITS +: COORD_BITS]);
      out_box12[k*FIELD_BITS +: FIELD_BITS] = ext[FIELD_BITS-1:0];
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cur_inc   = cur + NW'(1);
  assign last_one  = (cur_inc == fill);
  assign keep      = (rd_last == frame_cnt);
  assign report    = !keep && (rd_count >= min_needed);
  assign out_ok    = !m_tvalid || m_tready;
  assign advance   = !(report && have_pend && !out_ok);
  assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_INIT;

  // Sequencer: scan, update, sweep and release
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    fill_next      = fill;
    wptr_next      = wptr;
    have_pend_next = have_pend;
    pend_take      = 1'b0;
    box_take       = 1'b0;
    frame_next     = frame_cnt;
    ovf_next       = ovf_seen;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    out_load       = 1'b0;
    out_found      = 1'b0;
    out_box        = '0;
    out_first      = '0;
    out_last_f     = '0;
    out_tlast      = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cur_next = '0;
          if (s_tuser == CMD_EOF) begin
            wptr_next      = '0;
            have_pend_next = 1'b0;
            state_next     = (fill == '0) ? S_FLUSH : S_SWEEP;
          end else begin
            box_take = 1'b1;
            if (fill == '0) begin
              // Empty table: append straight away
              ram_we    = 1'b1;
              ram_wdata = {COUNT_INIT, frame_cnt, frame_cnt, in_box};
              fill_next = NW'(1);
            end else begin
              state_next = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        ram_raddr = cur_inc[AW-1:0];
        if (hit) begin
          // Refresh the first matching entry
          ram_we     = 1'b1;
          ram_waddr  = cur[AW-1:0];
          ram_wdata  = {count_inc, frame_cnt, rd_first, rd_box};
          state_next = S_IDLE;
        end else if (last_one) begin
          if (fill == NW'(TABLE_DEPTH)) begin
            ovf_next = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = fill[AW-1:0];
            ram_wdata = {COUNT_INIT, frame_cnt, frame_cnt, box_reg};
            fill_next = fill + NW'(1);
          end
          state_next = S_IDLE;
        end else begin
          cur_next = cur_inc;
        end
      end

      S_SWEEP: begin
        ram_raddr = advance ? cur_inc[AW-1:0] : cur[AW-1:0];
        if (advance) begin
          if (keep) begin
            // Compact surviving entries towards the front
            if (wptr != cur) begin
              ram_we    = 1'b1;
              ram_waddr = wptr[AW-1:0];
              ram_wdata = rd_data;
            end
            wptr_next = wptr + NW'(1);
          end else if (report) begin
            if (have_pend) begin
              out_load   = 1'b1;
              out_found  = 1'b1;
              out_box    = pend_box;
              out_first  = pend_first;
              out_last_f = pend_last;
            end
            pend_take      = 1'b1;
            have_pend_next = 1'b1;
          end
          if (last_one) begin
            fill_next  = keep ? wptr + NW'(1) : wptr;
            state_next = S_FLUSH;
          end else begin
            cur_next = cur_inc;
          end
        end
      end

      S_FLUSH: begin
        if (out_ok) begin
          // Release the final beat of the frame
          out_load  = 1'b1;
          out_tlast = 1'b1;
          if (have_pend) begin
            out_found  = 1'b1;
            out_box    = pend_box;
            out_first  = pend_first;
            out_last_f = pend_last;
          end
          have_pend_next = 1'b0;
          ovf_next       = 1'b0;
          frame_next     = frame_cnt + FRAME_BITS'(1);
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      fill      <= '0;
      wptr      <= '0;
      have_pend <= 1'b0;
      frame_cnt <= '0;
      ovf_seen  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      fill      <= fill_next;
      wptr      <= wptr_next;
      have_pend <= have_pend_next;
      frame_cnt <= frame_next;
      ovf_seen  <= ovf_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (box_take) begin
      box_reg <= in_box;
    end
    if (pend_take) begin
      pend_box   <= rd_box;
      pend_first <= rd_first;
      pend_last  <= rd_last;
    end
    if (out_load) begin
      m_tdata <= {out_last_f, out_first, out_box12};
      m_tuser <= {ovf_seen, out_found};
      m_tlast <= out_tlast;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist   <= MAX_DISTANCE_RST;
      min_needed <= MIN_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DISTANCE: max_dist   <= cfg_data[DIST_BITS-1:0];
        REG_MIN_FRAMES:   min_needed <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/sbt_checker.sv =====
`timescale 1ns / 1ps

module sbt_props (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [sbt_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input logic [sbt_pkg::OUT_TUSER_BITS-1:0] m_tuser,
  input logic                               m_tlast
);

  import sbt_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // End of frame keeps the input closed while the table is swept
  a_eof_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_EOF) |=> !s_tready)
    else $error("input reopened right after end of frame");

  // An empty marker always closes its frame
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty marker without last flag");

  // An empty marker carries no box or frame numbers
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
    else $error("empty marker with payload");

endmodule

bind stationary_box_tracker_core sbt_props u_sbt_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== bench/sbt_checker.sv =====
`timescale 1ns / 1ps

// Watch both streams and the register port, track the box table alongside
// the block and compare every output beat with the next predicted report.
module sbt_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [sbt_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // box_x, box_y, box_width, box_height
  input  logic                                s_tuser,  // command
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  // found_x, found_y, found_width, found_height, first_seen_frame, last_seen_frame
  input  logic [sbt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input  logic [sbt_pkg::OUT_TUSER_BITS-1:0]  m_tuser,  // found, table_overflow
  input  logic                                m_tlast,  // last_of_frame
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sbt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                  fail_count,
  output int                                  pending_count
);

  localparam int DEPTH       = sbt_pkg::TABLE_DEPTH_DEF;
  localparam int MAX_REPORTS = 16;
  localparam int FB          = sbt_pkg::FIELD_BITS;

  // x in the lowest field, then y, width, height
  typedef logic [3:0][FB-1:0] box_t;

  typedef struct packed {
    logic                           found;
    box_t                           box;
    logic [sbt_pkg::FRAME_BITS-1:0] first_frame;
    logic [sbt_pkg::FRAME_BITS-1:0] latest_frame;
    logic                           overflow;
    logic                           tail;
  } report_t;

  // Tracked table, kept in insertion order
  logic                            trk_valid [DEPTH];
  box_t                            trk_box   [DEPTH];
  logic [sbt_pkg::FRAME_BITS-1:0]  trk_first [DEPTH];
  logic [sbt_pkg::FRAME_BITS-1:0]  trk_last  [DEPTH];
  logic [sbt_pkg::COUNT_BITS-1:0]  trk_count [DEPTH];
  logic [sbt_pkg::FRAME_BITS-1:0]  frame_no;
  logic                            dropped_box;
  logic [sbt_pkg::DIST_BITS-1:0]   dist_limit;
  logic [sbt_pkg::CFG_DATA_BITS-1:0] min_count;

  report_t stationary_q [$];
  report_t got;
  report_t want;
  int      fails = 0;

  function automatic logic [FB-1:0] coord_gap(input logic [FB-1:0] a, input logic [FB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit is_near(input box_t a, input box_t b);
    for (int k = 0; k < 4; k++)
      if (coord_gap(a[k], b[k]) >= dist_limit) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    fails++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
  endtask

  task automatic check_field(input string what, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted) report_mismatch(what, seen, wanted);
  endtask

  // Match against the first close entry, else append, else drop
  task automatic track_box(input box_t box);
    int i;
    i = 0;
    while (i < DEPTH && trk_valid[i] && !is_near(box, trk_box[i])) i++;
    if (i == DEPTH) begin
      dropped_box = 1'b1;
    end else if (trk_valid[i]) begin
      if (trk_count[i] != sbt_pkg::COUNT_MAX) trk_count[i] = trk_count[i] + 1'b1;
      trk_last[i] = frame_no;
    end else begin
      trk_valid[i] = 1'b1;
      trk_box[i]   = box;
      trk_first[i] = frame_no;
      trk_last[i]  = frame_no;
      trk_count[i] = sbt_pkg::COUNT_INIT;
    end
  endtask

  // Drop stale entries, compact the rest and queue the reports of this frame
  task automatic close_frame();
    report_t batch [MAX_REPORTS];
    int      n;
    int      kept;
    n    = 0;
    kept = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (trk_valid[i]) begin
        if (trk_last[i] == frame_no) begin
          if (kept != i) begin
            trk_valid[kept] = 1'b1;
            trk_box[kept]   = trk_box[i];
            trk_first[kept] = trk_first[i];
            trk_last[kept]  = trk_last[i];
            trk_count[kept] = trk_count[i];
            trk_valid[i]    = 1'b0;
          end
          kept++;
        end else begin
          if (trk_count[i] >= min_count && n < MAX_REPORTS) begin
            batch[n]              = '0;
            batch[n].found        = 1'b1;
            batch[n].box          = trk_box[i];
            batch[n].first_frame  = trk_first[i];
            batch[n].latest_frame = trk_last[i];
            n++;
          end
          trk_valid[i] = 1'b0;
        end
      end
    end
    // Nothing stationary: a single empty marker
    if (n == 0) begin
      batch[0] = '0;
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      batch[i].overflow = dropped_box;
      batch[i].tail     = (i == n - 1);
      stationary_q.insert(stationary_q.size(), batch[i]);
    end
    dropped_box = 1'b0;
    frame_no    = frame_no + 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) trk_valid[i] = 1'b0;
      frame_no    = '0;
      dropped_box = 1'b0;
      dist_limit  = sbt_pkg::MAX_DISTANCE_RST;
      min_count   = sbt_pkg::MIN_FRAMES_RST;
      stationary_q.delete();
    end else begin
      // Register writes
      if (cfg_we) begin
        if (cfg_index == sbt_pkg::REG_MAX_DISTANCE) dist_limit = cfg_data[sbt_pkg::DIST_BITS-1:0];
        else if (cfg_index == sbt_pkg::REG_MIN_FRAMES) min_count = cfg_data;
      end
      // Output beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.found        = m_tuser[0];
        got.box          = m_tdata[4*FB-1:0];
        got.first_frame  = m_tdata[4*FB +: sbt_pkg::FRAME_BITS];
        got.latest_frame = m_tdata[4*FB+sbt_pkg::FRAME_BITS +: sbt_pkg::FRAME_BITS];
        got.overflow     = m_tuser[1];
        got.tail         = m_tlast;
        if (stationary_q.size() == 0) begin
          report_mismatch("beat with no report pending", got.found, 0);
        end else begin
          want = stationary_q.pop_front();
          check_field("found", got.found, want.found);
          check_field("found_x", got.box[0], want.box[0]);
          check_field("found_y", got.box[1], want.box[1]);
          check_field("found_width", got.box[2], want.box[2]);
          check_field("found_height", got.box[3], want.box[3]);
          check_field("first_seen_frame", got.first_frame, want.first_frame);
          check_field("last_seen_frame", got.latest_frame, want.latest_frame);
          check_field("table_overflow", got.overflow, want.overflow);
          check_field("last_of_frame", got.tail, want.tail);
        end
      end
      // Input beat into the table
      if (s_tvalid && s_tready) begin
        if (s_tuser == sbt_pkg::CMD_EOF) close_frame();
        else track_box(s_tdata);
      end
    end
    pending_count <= stationary_q.size();
    fail_count    <= fails;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 24;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [sbt_pkg::IN_TDATA_BITS-1:0]   s_tdata;  // box_x, box_y, box_width, box_height
  logic                                s_tuser;  // command
  logic                                m_tvalid;
  logic                                m_tready;
  // found_x, found_y, found_width, found_height, first_seen_frame, last_seen_frame
  logic [sbt_pkg::OUT_TDATA_BITS-1:0]  m_tdata;
  logic [sbt_pkg::OUT_TUSER_BITS-1:0]  m_tuser;  // found, table_overflow
  logic                                m_tlast;  // last_of_frame
  logic                                cfg_we;
  logic                                cfg_index;
  logic [sbt_pkg::CFG_DATA_BITS-1:0]   cfg_data;

  int fail_count;
  int pending_count;
  bit rush;
  bit calm;

  stationary_box_tracker_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sbt_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle cycles before the next beat; none during calm stretches or a rush
  function automatic int draw_wait();
    if (rush || calm) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [47:0] random_box();
    logic [15:0] hi;
    hi = 16'($urandom);
    return {hi, $urandom()};
  endfunction

  function automatic logic [47:0] make_box(input logic [11:0] x, input logic [11:0] y,
                                           input logic [11:0] w, input logic [11:0] h);
    return {h, w, y, x};
  endfunction

  // Nudge each field by a few pixels, wrapping at the coordinate range
  function automatic logic [47:0] jitter(input logic [47:0] b);
    for (int k = 0; k < 4; k++) b[12*k +: 12] = b[12*k +: 12] + 12'($urandom_range(0, 3));
    return b;
  endfunction

  // Present one beat and hold it until accepted
  task automatic send_beat(input logic cmd, input logic [47:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_box(input logic [47:0] data);
    send_beat(sbt_pkg::CMD_BOX, data);
  endtask

  task automatic end_frame();
    send_beat(sbt_pkg::CMD_EOF, random_box());
  endtask

  // Drop valid, let every pending report arrive, then let the block go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [11:0] near_limit, input logic [15:0] min_seen);
    write_reg(sbt_pkg::REG_MAX_DISTANCE, {4'd0, near_limit});
    write_reg(sbt_pkg::REG_MIN_FRAMES, min_seen);
  endtask

  // Frames built from a fixed set of jittered objects, with some noise boxes
  task automatic scene_phase(input logic [11:0] near_limit, input logic [15:0] min_seen,
                             input int items);
    logic [47:0] obj [20];
    int          n_obj;
    int          sent;
    set_limits(near_limit, min_seen);
    n_obj = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : $urandom_range(2, 7);
    for (int k = 0; k < n_obj; k++) obj[k] = random_box();
    sent = 0;
    while (sent < items) begin
      for (int k = 0; k < n_obj; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          send_box(jitter(obj[k]));
          sent++;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        send_box(random_box());
        sent++;
      end
      end_frame();
      sent++;
    end
    settle();
  endtask

  // Alternate calm stretches with idling
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(150, 600)) @(posedge clk);
      calm = 1'b1;
      repeat ($urandom_range(40, 200)) @(posedge clk);
      calm = 1'b0;
    end
  end

  // Receiver: stall a random number of cycles before each beat
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // End the run after too long without any beat or register write
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    do @(posedge clk); while (rst);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = sbt_pkg::CMD_BOX;
    cfg_we    = 1'b0;
    cfg_index = sbt_pkg::REG_MAX_DISTANCE;
    cfg_data  = '0;
    rush      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset limits: empty frame, close and borderline matches, extremes
    end_frame();
    send_box(make_box(12'd0, 12'd0, 12'd0, 12'd0));
    send_box(make_box(12'd9, 12'd9, 12'd9, 12'd9));
    send_box(make_box(12'd10, 12'd0, 12'd0, 12'd0));
    send_box(make_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    end_frame();
    send_box(make_box(12'd4086, 12'd4090, 12'd4095, 12'd4088));
    end_frame();
    settle();

    // Zero distance: identical boxes all append until the table is full
    set_limits(12'd0, 16'd1);
    repeat (16) send_box(make_box(12'h555, 12'hAAA, 12'h555, 12'hAAA));
    end_frame();
    end_frame();
    settle();

    // Widest distance: drive one entry's count exactly up to the minimum
    set_limits(12'hFFF, 16'd30);
    rush = 1'b1;
    repeat (30)
      send_box(make_box(12'($urandom_range(1, 4094)), 12'($urandom_range(1, 4094)),
                        12'($urandom_range(1, 4094)), 12'($urandom_range(1, 4094))));
    end_frame();
    end_frame();
    settle();
    rush = 1'b0;

    // Random scenes across a spread of limits
    scene_phase(12'd10, 16'd3, 50);
    scene_phase(12'hFFF, 16'd2, 45);
    scene_phase(12'd1, 16'd1, 45);
    scene_phase(12'd0, 16'd0, 45);
    scene_phase(12'd6, 16'd2, 55);
    scene_phase(12'($urandom_range(2, 40)), 16'($urandom_range(1, 6)), 50);

    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
